FILE: design/mmul4_pkg.sv
package mmul4_pkg;

  localparam int DIM    = 4;
  localparam int CELLS  = DIM * DIM;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int K_W    = $clog2(DIM);
  localparam int DATA_W = 32;
  localparam int FRAC   = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + K_W;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // flags that travel with one multiply through the pipeline
  typedef struct packed {
    logic first_k;
    logic last_k;
    logic last_el;
  } tag_t;

endpackage

FILE: design/matrix_multiply_4x4_top.sv
// 4x4 signed Q16.16 matrix product with one shared multiply-accumulate unit.
// input channel (in_*): sixteen beats, each carrying one left element and the
// right element at the same row-major position. in_tready is high while the
// block loads; after the sixteenth beat it drops until the product is out.
// result channel (out_*): sixteen beats of the product in row-major order,
// tuser set when the element was clipped to 32 bits, tlast on the sixteenth.
// each element is the exact sum of four 32x32 products, shifted right by 16
// (toward minus infinity) and saturated.
// flow: loading accepts one beat per cycle while in_tvalid is high. one 32x32
// multiplier serves every product, so each result is built from four products
// in turn; each product passes the read registers and the product register,
// and a finished sum is shifted, saturated and written to the output register.
// the next load starts as soon as the last result sits in the output register.
// a stall on out_tready freezes the whole compute pipeline; nothing is lost.
// reset (rst_n low, synchronous) returns the block to loading with an empty
// load count and no result pending; stored elements are not cleared.
module matrix_multiply_4x4_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // left_element [31:0], right_element [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // product_element [31:0]
  output logic        out_tuser,  // saturated [0]
  output logic        out_tlast
);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam int IDX_W  = mmul4_pkg::IDX_W;
  localparam int K_W    = mmul4_pkg::K_W;
  localparam int DATA_W = mmul4_pkg::DATA_W;
  localparam int PROD_W = mmul4_pkg::PROD_W;
  localparam int ACC_W  = mmul4_pkg::ACC_W;
  localparam int FRAC   = mmul4_pkg::FRAC;
  localparam int HI_LO  = FRAC + DATA_W - 1;

  logic                 state_r, state_nxt;
  logic [IDX_W-1:0]     load_cnt_r, load_cnt_nxt;
  logic [K_W-1:0]       row_r, row_nxt, col_r, col_nxt, k_r, k_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 adv, issue, in_acc;

  mmul4_pkg::elem_t     left_mem  [mmul4_pkg::CELLS];
  mmul4_pkg::elem_t     right_mem [mmul4_pkg::CELLS];
  logic [IDX_W-1:0]     l_addr, r_addr;

  mmul4_pkg::elem_t     rd_l_r, rd_r_r;
  logic                 s1_vld_r;
  mmul4_pkg::tag_t      s1_tag_r, iss_tag;
  mmul4_pkg::prod_t     prod_r;
  logic                 s2_vld_r;
  mmul4_pkg::tag_t      s2_tag_r;
  mmul4_pkg::acc_t      acc_r, acc_sum, shifted;
  logic                 fits;

  logic                 out_vld_r;
  logic [DATA_W-1:0]    out_data_r;
  logic                 out_sat_r, out_last_r;

  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign adv        = !out_vld_r || out_tready;
  assign issue      = (state_r == ST_RUN) && !iss_done_r && adv;

  assign l_addr = IDX_W'(row_r) * IDX_W'(mmul4_pkg::DIM) + IDX_W'(k_r);
  assign r_addr = IDX_W'(k_r) * IDX_W'(mmul4_pkg::DIM) + IDX_W'(col_r);

  assign iss_tag.first_k = (k_r == '0);
  assign iss_tag.last_k  = (k_r == K_W'(mmul4_pkg::DIM - 1));
  assign iss_tag.last_el = (row_r == K_W'(mmul4_pkg::DIM - 1)) &&
                           (col_r == K_W'(mmul4_pkg::DIM - 1));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    iss_done_nxt = iss_done_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (load_cnt_r == IDX_W'(mmul4_pkg::CELLS - 1)) begin
            load_cnt_nxt = '0;
            state_nxt    = ST_RUN;
            row_nxt      = '0;
            col_nxt      = '0;
            k_nxt        = '0;
            iss_done_nxt = 1'b0;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (iss_tag.last_k) begin
            k_nxt = '0;
            if (col_r == K_W'(mmul4_pkg::DIM - 1)) begin
              col_nxt = '0;
              if (row_r == K_W'(mmul4_pkg::DIM - 1)) begin
                iss_done_nxt = 1'b1;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
        if (adv && s2_vld_r && s2_tag_r.last_k && s2_tag_r.last_el) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      k_r        <= '0;
      iss_done_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      k_r        <= k_nxt;
      iss_done_r <= iss_done_nxt;
    end
  end

  // element stores
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_mem[load_cnt_r]  <= in_tdata[DATA_W-1:0];
      right_mem[load_cnt_r] <= in_tdata[2*DATA_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_l_r   <= left_mem[l_addr];
      rd_r_r   <= right_mem[r_addr];
      s1_tag_r <= iss_tag;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= rd_l_r * rd_r_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // accumulate, shift and saturate
  always_comb begin
    acc_sum = (s2_tag_r.first_k ? '0 : acc_r) + {{K_W{prod_r[PROD_W-1]}}, prod_r};
    shifted = acc_sum >>> FRAC;
    fits    = (&acc_sum[ACC_W-1:HI_LO]) || !(|acc_sum[ACC_W-1:HI_LO]);
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r) begin
      acc_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s2_vld_r && s2_tag_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r && s2_tag_r.last_k) begin
      out_last_r <= s2_tag_r.last_el;
      out_sat_r  <= !fits;
      if (fits) begin
        out_data_r <= shifted[DATA_W-1:0];
      end else if (acc_sum[ACC_W-1]) begin
        out_data_r <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        out_data_r <= {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

endmodule
